// File: rtl/core/rle8_pkg.sv
`timescale 1ns / 1ps

package rle8_pkg;

  // Largest frame dimension; register values above it act as this value
  localparam logic [12:0] MAX_DIM = 13'd4096;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;

  // Result status codes
  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;
  localparam logic [1:0] ST_SKIP = 2'd3;

  // Escape codes following a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  // Command phase, one-hot
  typedef enum logic [5:0] {
    PH_COUNT = 6'b000001,
    PH_VALUE = 6'b000010,
    PH_DX    = 6'b000100,
    PH_DY    = 6'b001000,
    PH_LIT   = 6'b010000,
    PH_PAD   = 6'b100000
  } phase_t;

endpackage

// File: rtl/core/rle8_bitmap_decoder.sv
`timescale 1ns / 1ps

// A result is registered and presented in the cycle after its input byte is accepted.
// Throughput: one byte per cycle; the single output register refills in the
// cycle it is taken, so input stalls only while a result waits unread.
// Reset (rst_n low, synchronous): width and height return to 1, the decoder
// re-arms at the bottom row and the output register empties.
module rle8_bitmap_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // compressed byte requests
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // run write requests
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_enable,
  output logic [11:0] out_row,
  output logic [11:0] out_column,
  output logic [7:0]  out_run_length,
  output logic [7:0]  out_pixel_value,
  output logic [1:0]  out_status,
  // configuration write requests
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);

  import rle8_pkg::*;

  // configuration
  logic [12:0] frame_width_r, frame_height_r;
  logic [12:0] width_eff, height_eff;
  logic [12:0] width_cfg_nxt, height_cfg_nxt;

  // decoder state
  phase_t             phase_r, phase_nxt;
  logic [7:0]         pending_count_r, pending_count_nxt;
  logic [12:0]        cursor_column_r, cursor_column_nxt;
  logic signed [13:0] cursor_row_r, cursor_row_nxt;
  logic [7:0]         literal_left_r, literal_left_nxt;
  logic               literal_odd_r, literal_odd_nxt;
  logic [7:0]         saved_delta_column_r, saved_delta_column_nxt;
  logic               frame_finished_r, frame_finished_nxt;

  // result register
  logic        out_valid_r;
  logic        we_r;
  logic [11:0] row_r, col_r;
  logic [7:0]  len_r, pix_r;
  logic [1:0]  status_r;

  logic        we_c;
  logic [11:0] row_c, col_c;
  logic [7:0]  len_c, pix_c;
  logic [1:0]  status_c;
  logic        err_c;

  logic        in_acc, cfg_acc, rearm;
  logic [13:0] run_end, lit_end, delta_col;
  logic signed [13:0] delta_row, row_init;
  logic [7:0]  lit_dec;

  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid;

  assign width_eff  = (frame_width_r > MAX_DIM) ? MAX_DIM : frame_width_r;
  assign height_eff = (frame_height_r > MAX_DIM) ? MAX_DIM : frame_height_r;

  // bound sums
  assign run_end   = {1'b0, cursor_column_r} + {6'd0, pending_count_r};
  assign lit_end   = {1'b0, cursor_column_r} + {6'd0, in_data_byte};
  assign delta_col = {1'b0, cursor_column_r} + {6'd0, saved_delta_column_r};
  assign delta_row = cursor_row_r - $signed({6'd0, in_data_byte});
  assign lit_dec   = literal_left_r - 8'd1;

  // config register next values
  always_comb begin
    width_cfg_nxt  = frame_width_r;
    height_cfg_nxt = frame_height_r;
    if (cfg_acc && cfg_index == REG_FRAME_WIDTH) begin
      width_cfg_nxt = cfg_data;
    end
    if (cfg_acc && cfg_index == REG_FRAME_HEIGHT) begin
      height_cfg_nxt = cfg_data;
    end
  end

  // starting row taken from the height in force after this cycle
  always_comb begin
    logic [12:0] h;
    h = (height_cfg_nxt > MAX_DIM) ? MAX_DIM : height_cfg_nxt;
    row_init = $signed({1'b0, h}) - 14'sd1;
  end

  // per-byte decode
  always_comb begin
    phase_nxt              = phase_r;
    pending_count_nxt      = pending_count_r;
    cursor_column_nxt      = cursor_column_r;
    cursor_row_nxt         = cursor_row_r;
    literal_left_nxt       = literal_left_r;
    literal_odd_nxt        = literal_odd_r;
    saved_delta_column_nxt = saved_delta_column_r;
    frame_finished_nxt     = frame_finished_r;
    we_c     = 1'b0;
    row_c    = 12'd0;
    col_c    = 12'd0;
    len_c    = 8'd0;
    pix_c    = 8'd0;
    status_c = ST_RUN;
    err_c    = 1'b0;

    if (frame_finished_r) begin
      status_c = ST_SKIP;
    end else begin
      case (phase_r)
        PH_VALUE: begin
          if (pending_count_r != 8'd0) begin
            if (cursor_row_r < 0 || run_end > {1'b0, width_eff}) begin
              err_c = 1'b1;
            end else begin
              we_c  = 1'b1;
              row_c = cursor_row_r[11:0];
              col_c = cursor_column_r[11:0];
              len_c = pending_count_r;
              pix_c = in_data_byte;
              cursor_column_nxt = run_end[12:0];
              phase_nxt = PH_COUNT;
            end
          end else if (in_data_byte == ESC_EOL) begin
            cursor_column_nxt = 13'd0;
            cursor_row_nxt = (cursor_row_r <= -14'sd1) ? -14'sd2 : cursor_row_r - 14'sd1;
            phase_nxt = PH_COUNT;
          end else if (in_data_byte == ESC_EOB) begin
            status_c = ST_END;
            frame_finished_nxt = 1'b1;
          end else if (in_data_byte == ESC_DELTA) begin
            phase_nxt = PH_DX;
          end else begin
            if (cursor_row_r < 0 || lit_end > {1'b0, width_eff}) begin
              err_c = 1'b1;
            end else begin
              literal_left_nxt = in_data_byte;
              literal_odd_nxt  = in_data_byte[0];
              phase_nxt = PH_LIT;
            end
          end
        end
        PH_DX: begin
          saved_delta_column_nxt = in_data_byte;
          phase_nxt = PH_DY;
        end
        PH_DY: begin
          if (delta_col > {1'b0, width_eff} || delta_row < -14'sd1) begin
            err_c = 1'b1;
          end else begin
            cursor_column_nxt = delta_col[12:0];
            cursor_row_nxt = delta_row;
            phase_nxt = PH_COUNT;
          end
        end
        PH_LIT: begin
          we_c  = 1'b1;
          row_c = (cursor_row_r < 0) ? 12'd0 : cursor_row_r[11:0];
          col_c = cursor_column_r[11:0];
          len_c = 8'd1;
          pix_c = in_data_byte;
          cursor_column_nxt = cursor_column_r + 13'd1;
          literal_left_nxt = lit_dec;
          if (lit_dec == 8'd0) begin
            phase_nxt = literal_odd_r ? PH_PAD : PH_COUNT;
          end
        end
        PH_PAD: begin
          phase_nxt = PH_COUNT;
        end
        default: begin
          pending_count_nxt = in_data_byte;
          phase_nxt = PH_VALUE;
        end
      endcase
      if (err_c) begin
        status_c = ST_ERR;
        frame_finished_nxt = 1'b1;
      end
    end

    // truncated frame
    if (in_last_byte && status_c == ST_RUN) begin
      status_c = ST_ERR;
    end
    if (status_c != ST_RUN) begin
      we_c  = 1'b0;
      row_c = 12'd0;
      col_c = 12'd0;
      len_c = 8'd0;
      pix_c = 8'd0;
    end
  end

  // a write to one of the frame registers, or accepting the last byte, re-arms the decoder
  assign rearm = (cfg_acc && (cfg_index == REG_FRAME_WIDTH ||
                              cfg_index == REG_FRAME_HEIGHT)) ||
                 (in_acc && in_last_byte);

  // configuration and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r        <= 13'd1;
      frame_height_r       <= 13'd1;
      phase_r              <= PH_COUNT;
      pending_count_r      <= 8'd0;
      cursor_column_r      <= 13'd0;
      cursor_row_r         <= 14'sd0;
      literal_left_r       <= 8'd0;
      literal_odd_r        <= 1'b0;
      saved_delta_column_r <= 8'd0;
      frame_finished_r     <= 1'b0;
    end else begin
      frame_width_r  <= width_cfg_nxt;
      frame_height_r <= height_cfg_nxt;
      if (rearm) begin
        phase_r              <= PH_COUNT;
        pending_count_r      <= 8'd0;
        cursor_column_r      <= 13'd0;
        cursor_row_r         <= row_init;
        literal_left_r       <= 8'd0;
        literal_odd_r        <= 1'b0;
        saved_delta_column_r <= 8'd0;
        frame_finished_r     <= 1'b0;
      end else if (in_acc) begin
        phase_r              <= phase_nxt;
        pending_count_r      <= pending_count_nxt;
        cursor_column_r      <= cursor_column_nxt;
        cursor_row_r         <= cursor_row_nxt;
        literal_left_r       <= literal_left_nxt;
        literal_odd_r        <= literal_odd_nxt;
        saved_delta_column_r <= saved_delta_column_nxt;
        frame_finished_r     <= frame_finished_nxt;
      end
    end
  end

  // output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      we_r     <= we_c;
      row_r    <= row_c;
      col_r    <= col_c;
      len_r    <= len_c;
      pix_r    <= pix_c;
      status_r <= status_c;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = we_r;
  assign out_row          = row_r;
  assign out_column       = col_r;
  assign out_run_length   = len_r;
  assign out_pixel_value  = pix_r;
  assign out_status       = status_r;

endmodule
